### src/pee_pkg.sv
// package for the prefix expression evaluator
// holds error codes, symbol codes, sequencer states and default sizes; no dependencies
`timescale 1ns / 1ps
package pee_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_PLUS  = 8'h2b;
  localparam logic [7:0] SYM_MINUS = 8'h2d;
  localparam logic [7:0] SYM_MUL   = 8'h2a;
  localparam logic [7:0] SYM_DIV   = 8'h2f;
  localparam logic [7:0] SYM_MOD   = 8'h25;
  localparam logic [7:0] SYM_POW   = 8'h24;
  localparam logic [7:0] SYM_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_DIVZ  = 3'd3,
    ERR_DEPTH = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_LOAD, ST_RUN, ST_PUSH, ST_RD_BOT, ST_EMIT, ST_OUT
  } state_t;

  // command to the bit-serial arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

  // status back from the arithmetic unit
  typedef struct packed {
    logic done;
    logic divz;
  } alu_sts_t;

  function automatic logic is_op(input logic [7:0] s);
    return s == SYM_PLUS || s == SYM_MINUS || s == SYM_MUL ||
           s == SYM_DIV || s == SYM_MOD || s == SYM_POW;
  endfunction

  function automatic op_t sym_to_op(input logic [7:0] s);
    op_t o;
    case (s)
      SYM_PLUS:  o = OP_ADD;
      SYM_MINUS: o = OP_SUB;
      SYM_MUL:   o = OP_MUL;
      SYM_DIV:   o = OP_DIV;
      SYM_MOD:   o = OP_MOD;
      default:   o = OP_POW;
    endcase
    return o;
  endfunction

endpackage

### src/pee_alu.sv
// bit-serial arithmetic unit: add/sub/mul/div/mod take one operand bit per cycle
// and pow one exponent bit per multiply and squaring step pair; uses pee_pkg
`timescale 1ns / 1ps
module pee_alu #(
  parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pee_pkg::alu_cmd_t      cmd,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output pee_pkg::alu_sts_t      sts,
  output logic [VALUE_WIDTH-1:0] result
);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [CW-1:0] LAST = CW'(VALUE_WIDTH - 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  pee_pkg::op_t           op;
  logic [VALUE_WIDTH-1:0] x;    // multiplicand / dividend / square
  logic [VALUE_WIDTH-1:0] y;    // multiplier / divisor / exponent shift
  logic [VALUE_WIDTH-1:0] acc;  // sum / quotient / product
  logic [VALUE_WIDTH-1:0] rem;
  logic                   carry;
  logic                   neg_q;
  logic                   neg_r;
  logic                   done;
  logic                   divz;
  logic                   pow_sq;  // power: clear for the multiply step, set for the squaring step

  logic [VALUE_WIDTH-1:0] ma;
  logic [VALUE_WIDTH-1:0] mb;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH-1:0] rem_sh;
  logic                   sum_bit;
  logic                   bb;
  logic [VALUE_WIDTH-1:0] q_fin;
  logic [VALUE_WIDTH-1:0] r_fin;

  assign ma = a[VALUE_WIDTH-1] ? -a : a;
  assign mb = b[VALUE_WIDTH-1] ? -b : b;
  assign rem_sh = {rem[VALUE_WIDTH-2:0], x[VALUE_WIDTH-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, y};
  assign bb = (op == pee_pkg::OP_SUB) ? ~y[0] : y[0];
  assign sum_bit = x[0] ^ bb ^ carry;

  // final fix-up of the serial results
  assign q_fin = {acc[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
  assign r_fin = trial[VALUE_WIDTH] ? rem_sh : trial[VALUE_WIDTH-1:0];

  assign sts = '{done: done, divz: divz};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy   <= 1'b1;
      op     <= cmd.op;
      cnt    <= '0;
      divz   <= 1'b0;
      rem    <= '0;
      pow_sq <= 1'b0;
      neg_q  <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      neg_r  <= a[VALUE_WIDTH-1];
      carry  <= (cmd.op == pee_pkg::OP_SUB);
      case (cmd.op)
        pee_pkg::OP_DIV, pee_pkg::OP_MOD: begin
          x <= ma;
          y <= mb;
          acc <= '0;
          if (b == '0) begin
            divz <= 1'b1;
            busy <= 1'b0;
            done <= 1'b1;
            result <= '0;
          end
        end
        pee_pkg::OP_POW: begin
          x <= a;
          y <= b;
          acc <= VALUE_WIDTH'(1);
          if (b[VALUE_WIDTH-1]) begin
            busy <= 1'b0;
            done <= 1'b1;
            if (a == VALUE_WIDTH'(1)) result <= VALUE_WIDTH'(1);
            else if (a == '1) result <= b[0] ? '1 : VALUE_WIDTH'(1);
            else result <= '0;
          end
        end
        default: begin
          x <= a;
          y <= b;
          acc <= '0;
        end
      endcase
    end else if (busy) begin
      case (op)
        pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
          acc   <= {sum_bit, acc[VALUE_WIDTH-1:1]};
          carry <= (x[0] & bb) | (carry & (x[0] ^ bb));
          x     <= x >> 1;
          y     <= y >> 1;
        end
        pee_pkg::OP_MUL: begin
          if (y[0]) acc <= acc + x;
          x <= x << 1;
          y <= y >> 1;
        end
        pee_pkg::OP_DIV, pee_pkg::OP_MOD: begin
          x   <= x << 1;
          acc <= {acc[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
          rem <= trial[VALUE_WIDTH] ? rem_sh : trial[VALUE_WIDTH-1:0];
        end
        default: begin
          // power: a multiply step, then a squaring step, for each exponent bit
          if (!pow_sq) begin
            if (y[0]) acc <= acc * x;
          end else begin
            x <= x * x;
            y <= y >> 1;
          end
          pow_sq <= ~pow_sq;
        end
      endcase
      if (op != pee_pkg::OP_POW || pow_sq) cnt <= cnt + 1'b1;
      if (cnt == LAST && (op != pee_pkg::OP_POW || pow_sq)) begin
        busy <= 1'b0;
        done <= 1'b1;
        case (op)
          pee_pkg::OP_ADD, pee_pkg::OP_SUB: result <= {sum_bit, acc[VALUE_WIDTH-1:1]};
          pee_pkg::OP_MUL: result <= y[0] ? acc + x : acc;
          pee_pkg::OP_DIV: result <= neg_q ? -q_fin : q_fin;
          pee_pkg::OP_MOD: result <= neg_r ? -r_fin : r_fin;
          default: result <= acc;
        endcase
      end
    end
  end
endmodule

### src/pee_stack.sv
// operand stack memory, one write and one registered read port
// no dependencies beyond parameters
`timescale 1ns / 1ps
module pee_stack #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  logic [VALUE_WIDTH-1:0]         wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output logic [VALUE_WIDTH-1:0]         rdata
);
  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/prefix_expression_evaluator.sv
// top level of the prefix expression evaluator: sequencer, stack, serial alu
// depends on pee_pkg, pee_stack, pee_alu
//
//  channel | signals                               | dir
//  in      | in_valid in_ready symbol final_symbol | sink
//  out     | out_valid out_ready value status      | source
//
// a space or a digit is taken in the idle state; an operator goes through accept,
// two stack reads, alu load, VALUE_WIDTH serial steps plus done, and push; power
// has a multiply and a squaring step per exponent bit, and divide by zero or a
// negative exponent skips them; a final beat then reads and outputs the bottom entry.
// one item is in work at a time; the result sits in an output register so a
// stalled out_ready holds only the next final beat.
// reset clears depth, error and the handshakes; stack contents stay undefined.
`timescale 1ns / 1ps
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    symbol,
  input  logic                          final_symbol,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic [2:0]                    status
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  pee_pkg::state_t state, state_next;
  logic [DW-1:0]   depth;
  pee_pkg::err_t   err;
  logic            fin;     // final flag of the beat in work
  pee_pkg::op_t    op;
  logic [VALUE_WIDTH-1:0] opa;
  logic [VALUE_WIDTH-1:0] opb;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  pee_pkg::alu_cmd_t      cmd;
  pee_pkg::alu_sts_t      sts;
  logic [VALUE_WIDTH-1:0] alu_res;

  pee_stack #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  pee_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
    .clk(clk), .rst(rst), .cmd(cmd), .a(opa), .b(opb),
    .sts(sts), .result(alu_res)
  );

  logic accept;
  logic sym_op;
  logic out_free;   // output register empty or being taken this cycle
  assign in_ready = (state == pee_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign sym_op   = pee_pkg::is_op(symbol);
  assign out_free = !out_valid || out_ready;

  // a push on a full stack (an operator with fewer than two entries is caught apart)
  logic push_full;
  assign push_full = depth == FULL;

  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = depth[AW-1:0];
    wdata = VALUE_WIDTH'(symbol) - VALUE_WIDTH'(pee_pkg::SYM_ZERO);
    raddr = AW'(depth - 1'b1);
    cmd   = '{start: 1'b0, op: op};
    case (state)
      pee_pkg::ST_IDLE: begin
        if (accept) begin
          if (symbol == pee_pkg::SYM_SPACE) begin
            state_next = final_symbol ? pee_pkg::ST_RD_BOT : pee_pkg::ST_IDLE;
          end else if (sym_op) begin
            state_next = (depth < DW'(2)) ?
              (final_symbol ? pee_pkg::ST_RD_BOT : pee_pkg::ST_IDLE) : pee_pkg::ST_RD_A;
          end else begin
            we = !push_full;
            state_next = final_symbol ? pee_pkg::ST_RD_BOT : pee_pkg::ST_IDLE;
          end
        end
      end
      pee_pkg::ST_RD_A: begin
        raddr = AW'(depth - 2'd2);
        state_next = pee_pkg::ST_RD_B;
      end
      pee_pkg::ST_RD_B:  state_next = pee_pkg::ST_LOAD;
      pee_pkg::ST_LOAD: begin
        cmd.start = 1'b1;
        state_next = pee_pkg::ST_RUN;
      end
      pee_pkg::ST_RUN: begin
        if (sts.done) state_next = pee_pkg::ST_PUSH;
      end
      pee_pkg::ST_PUSH: begin
        we    = 1'b1;
        wdata = alu_res;
        state_next = fin ? pee_pkg::ST_RD_BOT : pee_pkg::ST_IDLE;
      end
      pee_pkg::ST_RD_BOT: begin
        raddr = '0;
        state_next = pee_pkg::ST_EMIT;
      end
      pee_pkg::ST_EMIT: begin
        raddr = '0;
        state_next = pee_pkg::ST_OUT;
      end
      pee_pkg::ST_OUT: begin
        // bottom entry stays on the read port until the output register frees up
        raddr = '0;
        if (out_free) state_next = pee_pkg::ST_IDLE;
      end
      default: state_next = pee_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pee_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      err       <= pee_pkg::ERR_NONE;
      out_valid <= 1'b0;
      fin       <= 1'b0;
    end else begin
      if (state == pee_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        pee_pkg::ST_IDLE: begin
          if (accept) begin
            fin <= final_symbol;
            op  <= pee_pkg::sym_to_op(symbol);
            if (symbol == pee_pkg::SYM_SPACE) begin
            end else if (sym_op) begin
              if (depth < DW'(2) && err == pee_pkg::ERR_NONE) err <= pee_pkg::ERR_UNDER;
            end else if (push_full) begin
              if (err == pee_pkg::ERR_NONE) err <= pee_pkg::ERR_OVER;
            end else begin
              depth <= depth + 1'b1;
            end
          end
        end
        pee_pkg::ST_RD_A: opa <= rdata;          // top entry, left operand
        pee_pkg::ST_RD_B: opb <= rdata;          // next entry, right operand
        pee_pkg::ST_LOAD: begin
          depth <= depth - DW'(2);
        end
        pee_pkg::ST_PUSH: begin
          depth <= depth + 1'b1;
        end
        pee_pkg::ST_RUN: begin
          if (sts.done && sts.divz && err == pee_pkg::ERR_NONE) err <= pee_pkg::ERR_DIVZ;
        end
        pee_pkg::ST_OUT: begin
          if (out_free) begin
            value <= (depth != '0) ? rdata : '0;
            if (err != pee_pkg::ERR_NONE) status <= err;
            else status <= (depth != DW'(1)) ? pee_pkg::ERR_DEPTH : pee_pkg::ERR_NONE;
            depth <= '0;
            err   <= pee_pkg::ERR_NONE;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### src/pee_checker.sv
// port-level checker for the prefix expression evaluator, bound to the top level
// depends on pee_pkg and the prefix_expression_evaluator ports
`timescale 1ns / 1ps
module pee_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result beat dropped while stalled");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= pee_pkg::ERR_DEPTH)
    else $error("status code out of range");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before accept");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind prefix_expression_evaluator pee_checker u_pee_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status)
);
